[hw/rtl/qrm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package qrm_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = DATA_WIDTH - 2;
    localparam int PROD_W      = 2 * DATA_WIDTH;
    // squared norm reaches 4 * 2^(2*DATA_WIDTH-2), one bit over a product
    localparam int N_W         = PROD_W + 1;
    localparam int NUM_W       = N_W + 1;
    // partial remainder stays below twice the norm
    localparam int REM_W       = N_W + 1;
    // unrounded quotient reaches 2^(FRAC_BITS+1)
    localparam int QUO_W       = DATA_WIDTH;
    localparam int DIV_STEPS   = QUO_W;
    localparam int NUM_ENTRIES = 9;

    localparam int E_R00 = 0;
    localparam int E_R01 = 1;
    localparam int E_R02 = 2;
    localparam int E_R10 = 3;
    localparam int E_R11 = 4;
    localparam int E_R12 = 5;
    localparam int E_R20 = 6;
    localparam int E_R21 = 7;
    localparam int E_R22 = 8;

    localparam logic [DATA_WIDTH-1:0] ONE_Q =
        {{(DATA_WIDTH-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [NUM_W-1:0]      num_t;
    typedef logic [N_W-1:0]               nrm_t;
    typedef logic [REM_W-1:0]             rem_t;
    typedef logic [QUO_W-1:0]             quo_t;

    typedef struct packed {
        data_t x;
        data_t y;
        data_t z;
        data_t w;
    } quat_t;

    typedef struct packed {
        prod_t xx;
        prod_t yy;
        prod_t zz;
        prod_t ww;
        prod_t xy;
        prod_t zw;
        prod_t xz;
        prod_t yw;
        prod_t yz;
        prod_t xw;
    } prod_set_t;

    typedef struct packed {
        num_t [NUM_ENTRIES-1:0] num;
        nrm_t                   n;
    } sum_set_t;

    typedef struct packed {
        rem_t [NUM_ENTRIES-1:0] rem;
        quo_t [NUM_ENTRIES-1:0] quo;
        logic [NUM_ENTRIES-1:0] neg;
        nrm_t                   n;
        logic                   zero;
    } div_set_t;

    typedef struct packed {
        data_t [NUM_ENTRIES-1:0] r;
        logic                    invalid;
    } rot_t;

endpackage

`default_nettype wire

[hw/rtl/qrm_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface qrm_in_if;
    logic           valid;
    logic           ready;
    qrm_pkg::data_t quat_x;
    qrm_pkg::data_t quat_y;
    qrm_pkg::data_t quat_z;
    qrm_pkg::data_t quat_w;

    modport source (output valid, output quat_x, output quat_y, output quat_z,
                    output quat_w, input ready);
    modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                    input quat_w, output ready);
endinterface

`default_nettype wire

[hw/rtl/qrm_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface qrm_out_if;
    logic           valid;
    logic           ready;
    qrm_pkg::data_t r00;
    qrm_pkg::data_t r01;
    qrm_pkg::data_t r02;
    qrm_pkg::data_t r10;
    qrm_pkg::data_t r11;
    qrm_pkg::data_t r12;
    qrm_pkg::data_t r20;
    qrm_pkg::data_t r21;
    qrm_pkg::data_t r22;
    logic           invalid;

    modport source (output valid, output r00, output r01, output r02, output r10,
                    output r11, output r12, output r20, output r21, output r22,
                    output invalid, input ready);
    modport sink   (input valid, input r00, input r01, input r02, input r10,
                    input r11, input r12, input r20, input r21, input r22,
                    input invalid, output ready);
endinterface

`default_nettype wire

[hw/rtl/qrm_prod.sv]
`timescale 1ns / 1ps
`default_nettype none

module qrm_prod (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 advance,
    input  wire                 in_valid,
    input  qrm_pkg::quat_t      quat,
    output logic                valid,
    output qrm_pkg::prod_set_t  prod
);

    logic               valid_reg;
    qrm_pkg::prod_set_t prod_reg;
    qrm_pkg::prod_set_t prod_next;
    qrm_pkg::prod_t     ex;
    qrm_pkg::prod_t     ey;
    qrm_pkg::prod_t     ez;
    qrm_pkg::prod_t     ew;

    always_comb
    begin
        ex = qrm_pkg::prod_t'(quat.x);
        ey = qrm_pkg::prod_t'(quat.y);
        ez = qrm_pkg::prod_t'(quat.z);
        ew = qrm_pkg::prod_t'(quat.w);
        prod_next.xx = ex * ex;
        prod_next.yy = ey * ey;
        prod_next.zz = ez * ez;
        prod_next.ww = ew * ew;
        prod_next.xy = ex * ey;
        prod_next.zw = ez * ew;
        prod_next.xz = ex * ez;
        prod_next.yw = ey * ew;
        prod_next.yz = ey * ez;
        prod_next.xw = ex * ew;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
        end
    end

    assign valid = valid_reg;
    assign prod  = prod_reg;

endmodule

`default_nettype wire

[hw/rtl/qrm_sum.sv]
`timescale 1ns / 1ps
`default_nettype none

module qrm_sum (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 advance,
    input  wire                 in_valid,
    input  qrm_pkg::prod_set_t  prod,
    output logic                valid,
    output qrm_pkg::div_set_t   div
);

    logic              sum_valid_reg;
    qrm_pkg::sum_set_t sum_reg;
    qrm_pkg::sum_set_t sum_next;
    logic              div_valid_reg;
    qrm_pkg::div_set_t div_reg;
    qrm_pkg::div_set_t div_next;
    qrm_pkg::num_t     xx, yy, zz, ww, xy, zw, xz, yw, yz, xw;
    qrm_pkg::num_t     n_full;
    qrm_pkg::num_t     mag;

    // signed numerators; every one lies within plus or minus the norm
    always_comb
    begin
        xx = qrm_pkg::num_t'(prod.xx);
        yy = qrm_pkg::num_t'(prod.yy);
        zz = qrm_pkg::num_t'(prod.zz);
        ww = qrm_pkg::num_t'(prod.ww);
        xy = qrm_pkg::num_t'(prod.xy);
        zw = qrm_pkg::num_t'(prod.zw);
        xz = qrm_pkg::num_t'(prod.xz);
        yw = qrm_pkg::num_t'(prod.yw);
        yz = qrm_pkg::num_t'(prod.yz);
        xw = qrm_pkg::num_t'(prod.xw);
        n_full = xx + yy + zz + ww;
        sum_next.n = qrm_pkg::nrm_t'(n_full);
        sum_next.num[qrm_pkg::E_R00] =  xx - yy - zz + ww;
        sum_next.num[qrm_pkg::E_R11] = -xx + yy - zz + ww;
        sum_next.num[qrm_pkg::E_R22] = -xx - yy + zz + ww;
        sum_next.num[qrm_pkg::E_R01] = (xy - zw) <<< 1;
        sum_next.num[qrm_pkg::E_R10] = (xy + zw) <<< 1;
        sum_next.num[qrm_pkg::E_R02] = (xz + yw) <<< 1;
        sum_next.num[qrm_pkg::E_R20] = (xz - yw) <<< 1;
        sum_next.num[qrm_pkg::E_R12] = (yz - xw) <<< 1;
        sum_next.num[qrm_pkg::E_R21] = (yz + xw) <<< 1;
    end

    // split into sign and magnitude for the unsigned divider
    always_comb
    begin
        div_next.n    = sum_reg.n;
        div_next.zero = (sum_reg.n == '0);
        mag           = '0;
        for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++)
        begin
            div_next.neg[i] = sum_reg.num[i][qrm_pkg::NUM_W-1];
            mag             = div_next.neg[i] ? -sum_reg.num[i] : sum_reg.num[i];
            div_next.rem[i] = qrm_pkg::rem_t'(mag);
            div_next.quo[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            div_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sum_valid_reg <= in_valid;
            div_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg <= sum_next;
            div_reg <= div_next;
        end
    end

    assign valid = div_valid_reg;
    assign div   = div_reg;

endmodule

`default_nettype wire

[hw/rtl/qrm_div_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module qrm_div_step (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                advance,
    input  wire                in_valid,
    input  qrm_pkg::div_set_t  div_in,
    output logic               valid,
    output qrm_pkg::div_set_t  div_out
);

    logic              valid_reg;
    qrm_pkg::div_set_t div_reg;
    qrm_pkg::div_set_t div_next;
    qrm_pkg::rem_t     den;
    qrm_pkg::rem_t     diff;
    qrm_pkg::rem_t     kept;
    logic              ge;

    // one restoring step per lane; remainder stays below twice the norm after it
    always_comb
    begin
        div_next = div_in;
        den      = qrm_pkg::rem_t'(div_in.n);
        diff     = '0;
        kept     = '0;
        ge       = 1'b0;
        for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++)
        begin
            ge   = (div_in.rem[i] >= den);
            diff = div_in.rem[i] - den;
            kept = ge ? diff : div_in.rem[i];
            div_next.rem[i] = kept << 1;
            div_next.quo[i] = {div_in.quo[i][qrm_pkg::QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_reg <= div_next;
        end
    end

    assign valid   = valid_reg;
    assign div_out = div_reg;

endmodule

`default_nettype wire

[hw/rtl/qrm_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module qrm_out (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                advance,
    input  wire                in_valid,
    input  qrm_pkg::div_set_t  div,
    output logic               valid,
    output qrm_pkg::rot_t      rot
);

    logic                    valid_reg;
    qrm_pkg::rot_t           rot_reg;
    qrm_pkg::rot_t           rot_next;
    logic [qrm_pkg::QUO_W:0] inc;
    qrm_pkg::data_t          q;

    // quotient carries one extra fraction bit: add one and drop it to round
    // half away from zero; magnitude never exceeds 1.0, so no clamp is needed
    always_comb
    begin
        inc      = '0;
        q        = '0;
        rot_next.invalid = div.zero;
        for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++)
        begin
            inc = {1'b0, div.quo[i]} + {{qrm_pkg::QUO_W{1'b0}}, 1'b1};
            q   = qrm_pkg::data_t'(inc[qrm_pkg::QUO_W:1]);
            rot_next.r[i] = div.neg[i] ? -q : q;
            if (div.zero)
            begin
                rot_next.r[i] = '0;
            end
        end
        if (div.zero)
        begin
            rot_next.r[qrm_pkg::E_R00] = qrm_pkg::ONE_Q;
            rot_next.r[qrm_pkg::E_R11] = qrm_pkg::ONE_Q;
            rot_next.r[qrm_pkg::E_R22] = qrm_pkg::ONE_Q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rot_reg <= rot_next;
        end
    end

    assign valid = valid_reg;
    assign rot   = rot_reg;

endmodule

`default_nettype wire

[hw/rtl/quaternion_to_rotation_matrix_core.sv]
// Pipeline: 20 register stages (products, sums, sign split, 16 divide steps,
//   output).
// Throughput: one quaternion per cycle unless the output stalls; each divide stage
//   runs one restoring step per entry, so the unrolled divider sets the depth, not the rate.
// Reset: rst_n clears all stage valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_to_rotation_matrix_core (
    input  wire          clk,
    input  wire          rst_n,
    qrm_in_if.sink       quat,
    qrm_out_if.source    rot
);

    logic               advance;
    logic               out_valid;
    qrm_pkg::quat_t     quat_data;
    logic               prod_valid;
    qrm_pkg::prod_set_t prod;
    logic               chain_valid [qrm_pkg::DIV_STEPS+1];
    qrm_pkg::div_set_t  chain       [qrm_pkg::DIV_STEPS+1];
    qrm_pkg::rot_t      rot_data;

    // whole pipe moves together; hold everything while the result waits
    assign advance    = !out_valid || rot.ready;
    assign quat.ready = advance;

    assign quat_data.x = quat.quat_x;
    assign quat_data.y = quat.quat_y;
    assign quat_data.z = quat.quat_z;
    assign quat_data.w = quat.quat_w;

    qrm_prod u_prod (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (quat.valid),
        .quat     (quat_data),
        .valid    (prod_valid),
        .prod     (prod)
    );

    qrm_sum u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (prod_valid),
        .prod     (prod),
        .valid    (chain_valid[0]),
        .div      (chain[0])
    );

    for (genvar s = 0; s < qrm_pkg::DIV_STEPS; s++)
    begin : g_div
        qrm_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .in_valid (chain_valid[s]),
            .div_in   (chain[s]),
            .valid    (chain_valid[s+1]),
            .div_out  (chain[s+1])
        );
    end

    qrm_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (chain_valid[qrm_pkg::DIV_STEPS]),
        .div      (chain[qrm_pkg::DIV_STEPS]),
        .valid    (out_valid),
        .rot      (rot_data)
    );

    assign rot.valid   = out_valid;
    assign rot.r00     = rot_data.r[qrm_pkg::E_R00];
    assign rot.r01     = rot_data.r[qrm_pkg::E_R01];
    assign rot.r02     = rot_data.r[qrm_pkg::E_R02];
    assign rot.r10     = rot_data.r[qrm_pkg::E_R10];
    assign rot.r11     = rot_data.r[qrm_pkg::E_R11];
    assign rot.r12     = rot_data.r[qrm_pkg::E_R12];
    assign rot.r20     = rot_data.r[qrm_pkg::E_R20];
    assign rot.r21     = rot_data.r[qrm_pkg::E_R21];
    assign rot.r22     = rot_data.r[qrm_pkg::E_R22];
    assign rot.invalid = rot_data.invalid;

endmodule

`default_nettype wire
